/* rtl/pdsrm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdsrm_pkg: shared types and constants
// Field structs, frame job record, register indexes and FSM encodings for
// the peak-decay spectrum RMS level meter.
// ----------------------------------------------------------------------------
package pdsrm_pkg;

    localparam int MAX_BANDS  = 256;
    localparam int BAND_AW    = $clog2(MAX_BANDS);

    localparam int IDX_W      = 8;
    localparam int MAG_W      = 16;
    localparam int CODE_W     = 11;
    localparam int CNT_W      = 9;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = 40;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int PROD_W     = MAG_W + CODE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int JOB_DEPTH  = 2;

    localparam logic [MAG_W-1:0]  DECAY_RESET = 16'd62915;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 9'd256;
    localparam logic [CODE_W-1:0] CODE_FULL   = 11'd2047;
    localparam logic [MAG_W:0]    ONE_Q16     = 17'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY_FACTOR = 2'd0,
        REG_BAND_COUNT   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0] band_index;
        logic [MAG_W-1:0] band_magnitude;
        logic             frame_last;
    } band_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] level_code;
        logic [CODE_W-1:0] max_level_code;
    } level_result_t;

    // one finished frame handed from the accumulator to the root unit
    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic [CNT_W-1:0] divisor;
    } frame_job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_UPD,
        FR_ACC
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_SCALE,
        BK_DONE
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/pdsrm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdsrm_front: band smoothing and square accumulation
// Read-modify-write of the per-band smoothed store, square sum with
// saturation, and hand-off of each finished frame to the job queue.
// ----------------------------------------------------------------------------
module pdsrm_front
    import pdsrm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire band_item_t       item,
    input  wire logic [MAG_W-1:0] decay_factor,
    input  wire logic [CNT_W-1:0] band_count,
    output logic                  job_push,
    input  wire logic             job_full,
    output frame_job_t            job
);

    logic [MAG_W-1:0]     mem [MAX_BANDS];
    logic [MAX_BANDS-1:0] valid_reg, valid_next;

    front_state_t     state_reg, state_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic [BAND_AW-1:0] idx_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               last_reg;
    logic [MAG_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;
    logic [SQ_W-1:0]    prod_reg, prod_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;

    logic               accept;
    logic               mem_we;
    logic [BAND_AW-1:0] item_idx;
    logic [MAG_W-1:0]   rd_eff;
    logic [MAG_W-1:0]   decayed;
    logic [MAG_W-1:0]   smooth_new;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    assign item_idx   = item.band_index[BAND_AW-1:0];
    assign rd_eff     = rd_valid_reg ? rd_data_reg : '0;
    assign prod_next  = {{MAG_W{1'b0}}, rd_eff} * {{MAG_W{1'b0}}, decay_factor};
    assign decayed    = prod_reg[SQ_W-1:MAG_W];
    assign smooth_new = (decayed < mag_reg) ? mag_reg : decayed;
    assign sq_next    = {{MAG_W{1'b0}}, smooth_new} * {{MAG_W{1'b0}}, smooth_new};
    assign sum_wide   = {1'b0, sum_reg} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_reg};
    assign sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    assign job.square_sum = sum_sat;
    assign job.divisor    = (band_count == '0) ? CNT_W'(1) : band_count;

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        full       = 1'b1;
        accept     = 1'b0;
        mem_we     = 1'b0;
        job_push   = 1'b0;
        case (state_reg)
            FR_IDLE:
            begin
                full   = 1'b0;
                accept = push;
                if (push)
                begin
                    state_next = FR_MUL;
                end
            end
            FR_MUL:
            begin
                state_next = FR_UPD;
            end
            FR_UPD:
            begin
                mem_we              = 1'b1;
                valid_next[idx_reg] = 1'b1;
                state_next          = FR_ACC;
            end
            FR_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = sum_sat;
                    state_next = FR_IDLE;
                end
                else if (!job_full)
                begin
                    job_push   = 1'b1;
                    sum_next   = '0;
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            sum_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= smooth_new;
        end
        if (accept)
        begin
            rd_data_reg  <= mem[item_idx];
            rd_valid_reg <= valid_reg[item_idx];
            idx_reg      <= item_idx;
            mag_reg      <= item.band_magnitude;
            last_reg     <= item.frame_last;
        end
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
    end

endmodule
`default_nettype wire

/* rtl/pdsrm_job_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdsrm_job_fifo: frame job queue
// Short queue of finished frame sums between the accumulator and the root
// unit, so each side stalls on its own.
// ----------------------------------------------------------------------------
module pdsrm_job_fifo
    import pdsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire frame_job_t din,
    input  wire logic       pop,
    output logic            empty,
    output frame_job_t      dout
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    frame_job_t       entries_reg [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(JOB_DEPTH))
        else $error("job queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue popped while empty");

endmodule
`default_nettype wire

/* rtl/pdsrm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pdsrm_back: frame level unit
// Per frame: serial mean (sum / band count), serial square root, scaling to
// an 11-bit code, peak tracking and the result register.
// ----------------------------------------------------------------------------
module pdsrm_back
    import pdsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_empty,
    output logic            job_pop,
    input  wire frame_job_t job,
    input  wire logic       pop,
    output logic            empty,
    output level_result_t   result
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam int REM_W  = ROOT_W + 2;

    back_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]   dvd_reg, dvd_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [SUM_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   srem_reg, srem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [CODE_W-1:0]  peak_reg, peak_next;
    level_result_t      out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [CNT_W:0]     div_trial;
    logic               div_ge;
    logic [REM_W-1:0]   sq_shift;
    logic [REM_W-1:0]   sq_trial;
    logic               sq_ge;
    logic [MAG_W-1:0]   root_clamp;
    logic [CODE_W-1:0]  q_hi;
    logic [MAG_W:0]     q_rem;
    logic [CODE_W-1:0]  code;

    // restoring division, one quotient bit a cycle
    assign div_trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, div_reg});

    // digit-by-digit root, two radicand bits a cycle
    assign sq_shift = {srem_reg[REM_W-3:0], rad_reg[SUM_W-1:SUM_W-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    assign root_clamp = (|root_reg[ROOT_W-1:MAG_W]) ? '1 : root_reg[MAG_W-1:0];

    // x / 65535 for x < 2^27: x = q*65535 + (lo + q), one correction step
    assign q_hi  = prod_reg[PROD_W-1:MAG_W];
    assign q_rem = {1'b0, prod_reg[MAG_W-1:0]} + {{(MAG_W + 1 - CODE_W){1'b0}}, q_hi};
    assign code  = (q_rem >= ONE_Q16) ? q_hi + CODE_W'(1) : q_hi;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        prod_next      = prod_reg;
        peak_next      = peak_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        job_pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    dvd_next   = job.square_sum;
                    div_next   = job.divisor;
                    rem_next   = '0;
                    cnt_next   = STEP_W'(SUM_W - 1);
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                rem_next = div_ge ? CNT_W'(div_trial - {1'b0, div_reg})
                                  : div_trial[CNT_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], div_ge};
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    rad_next   = {dvd_reg[SUM_W-2:0], div_ge};
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = STEP_W'(ROOT_W - 1);
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                srem_next = sq_ge ? sq_shift - sq_trial : sq_shift;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                rad_next  = {rad_reg[SUM_W-3:0], 2'b00};
                cnt_next  = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                prod_next  = PROD_W'(root_clamp) * PROD_W'(CODE_FULL);
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    peak_next               = (code > peak_reg) ? code : peak_reg;
                    out_next.level_code     = code;
                    out_next.max_level_code = (code > peak_reg) ? code : peak_reg;
                    out_valid_next          = 1'b1;
                    state_next              = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    a_level_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.level_code <= out_reg.max_level_code))
        else $error("level code above reported maximum");

    a_max_is_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.max_level_code == peak_reg))
        else $error("reported maximum differs from peak register");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= $past(peak_reg))
        else $error("peak code decreased");

endmodule
`default_nettype wire

/* rtl/peak_decay_spectrum_rms_meter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// peak_decay_spectrum_rms_meter: peak-hold decay RMS level meter
// Smooths spectrum band magnitudes with per-band peak decay and reports the
// RMS level of each frame as an 11-bit code, with the running maximum.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------
//  input     push / full                item   (band_item_t)
//  result    pop / empty                result (level_result_t)
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  Front: store read, decay multiply, update and square, accumulate, one band
//  item at a time; full is low only between items.
//  Back: job pop, 40 divide steps, 20 root steps, scale and code per frame,
//  overlapped with the next frame through a 2-entry job queue.
//  Reset clears the smoothed store through per-band valid bits, no sweep.
//  A held result stalls the back end only; the front stalls once the
//  queue is full at a frame end.
// ----------------------------------------------------------------------------
module peak_decay_spectrum_rms_meter
    import pdsrm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire band_item_t            item,
    output logic                       empty,
    input  wire logic                  pop,
    output level_result_t             result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MAG_W-1:0] decay_reg, decay_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic       job_push, job_full, job_pop, job_empty;
    frame_job_t job_in, job_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        decay_next = decay_reg;
        count_next = count_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DECAY_FACTOR: decay_next = cfg_data[MAG_W-1:0];
                REG_BAND_COUNT:   count_next = cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
            count_reg <= COUNT_RESET;
        end
        else
        begin
            decay_reg <= decay_next;
            count_reg <= count_next;
        end
    end

    pdsrm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .decay_factor (decay_reg),
        .band_count   (count_reg),
        .job_push     (job_push),
        .job_full     (job_full),
        .job          (job_in)
    );

    pdsrm_job_fifo u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .full  (job_full),
        .din   (job_in),
        .pop   (job_pop),
        .empty (job_empty),
        .dout  (job_out)
    );

    pdsrm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (job_out),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the peak-decay spectrum RMS level meter
// A table of directed band items and register writes, then phases of random
// frames under changing decay and band-count settings. Each untyped result is
// checked against an in-bench model of the smoothing, the square sum, the
// root and the running peak code, under random bursts, gaps and result stalls.
// ----------------------------------------------------------------------------
module tb;
    import pdsrm_pkg::*;

    localparam int IDLE_LIMIT = 4000;   // cycles with no transaction at all
    localparam int HOLD_CYC   = 600;    // long result hold-off
    localparam int SETTLE_CYC = 16;     // lets the front end finish its last item
    localparam int N_PHASES   = 10;
    localparam int HOLD_PHASE = 2;
    localparam int SAT_PHASE  = 5;
    localparam int DIR_ROWS   = 23;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  data;
        band_item_t             band;
        bit                     typed;
        level_result_t          want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    band_item_t            item;
    logic                  empty;
    logic                  pop;
    level_result_t         result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model state
    logic [MAG_W-1:0]  smooth_mem [MAX_BANDS];
    logic [SUM_W-1:0]  sum_acc;
    logic [CODE_W-1:0] peak_lvl;
    logic [MAG_W-1:0]  decay_reg;
    logic [CNT_W-1:0]  count_reg;

    level_result_t level_q [$];
    level_result_t mon_want;

    int  fail_cnt;
    int  n_items;
    int  n_results;
    int  n_writes;
    int  idle_cyc;
    int  burst_left;
    int  gap_max;
    bit  hold_req;

    stim_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd0,   16'd0,     1'b1}, 1'b1, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd255, 16'd65535, 1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd254, 16'd65535, 1'b1}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_CFG,  REG_DECAY_FACTOR, 16'h0000, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_CFG,  REG_BAND_COUNT,   16'h0002, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd3,   16'd40000, 1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd3,   16'd1000,  1'b1}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd3,   16'd0,     1'b1}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_CFG,  REG_BAND_COUNT,   16'h0001, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd7,   16'd65535, 1'b1}, 1'b1,
          '{11'd2047, 11'd2047}},
        // band count zero acts as one
        '{ROW_CFG,  REG_BAND_COUNT,   16'h0000, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd8,   16'd65535, 1'b1}, 1'b1,
          '{11'd2047, 11'd2047}},
        '{ROW_CFG,  REG_DECAY_FACTOR, 16'hFFFF, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_CFG,  REG_BAND_COUNT,   16'h0100, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd10,  16'd65535, 1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd10,  16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd10,  16'd0,     1'b1}, 1'b0, '{11'd0, 11'd0}},
        // writes to unmapped indexes must change nothing
        '{ROW_CFG,  REG_SPARE_2,      16'hFFFF, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_CFG,  REG_SPARE_3,      16'hFFFF, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd11,  16'd1,     1'b1}, 1'b0, '{11'd0, 11'd0}},
        // upper data bits are not part of the band count
        '{ROW_CFG,  REG_BAND_COUNT,   16'hFE05, '{8'd0,   16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}},
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd200, 16'd12345, 1'b1}, 1'b0, '{11'd0, 11'd0}},
        // no frame end: the sum carries into the next frame
        '{ROW_ITEM, REG_DECAY_FACTOR, 16'h0000, '{8'd128, 16'd0,     1'b0}, 1'b0, '{11'd0, 11'd0}}
    };

    peak_decay_spectrum_rms_meter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = ROOT_W - 1; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= {24'd0, v})
                r = t;
        end
        return r[ROOT_W-1:0];
    endfunction

    // advance the model by one band item; returns 1 when a frame result is due
    function automatic bit predict_band(input band_item_t b, output level_result_t r);
        logic [31:0]       prod;
        logic [MAG_W-1:0]  s;
        logic [31:0]       sq;
        logic [SUM_W:0]    acc;
        logic [SUM_W-1:0]  mean;
        logic [ROOT_W-1:0] root;
        logic [31:0]       code;
        logic [CNT_W-1:0]  div;
        r = '0;
        prod = smooth_mem[b.band_index] * decay_reg;
        s = prod[31:16];
        if (s < b.band_magnitude)
            s = b.band_magnitude;
        smooth_mem[b.band_index] = s;
        sq = s * s;
        acc = {1'b0, sum_acc} + sq;
        sum_acc = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
        if (!b.frame_last)
            return 1'b0;
        div = (count_reg == '0) ? 9'd1 : count_reg;
        mean = sum_acc / div;
        root = floor_root(mean);
        if (root > ONE_Q16)
            root = ROOT_W'(ONE_Q16);
        code = root * CODE_FULL / ONE_Q16;
        if (code[CODE_W-1:0] > peak_lvl)
            peak_lvl = code[CODE_W-1:0];
        sum_acc = '0;
        r.level_code = code[CODE_W-1:0];
        r.max_level_code = peak_lvl;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        if (fail_cnt < 20)
            $display("MISMATCH @%0t: %s", $time, what);
        fail_cnt++;
    endtask

    // stop offering items, wait for every frame result, then let the front settle
    task automatic drain_idle();
        push <= 1'b0;
        burst_left = 0;
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DECAY_FACTOR: decay_reg = data;
            REG_BAND_COUNT:   count_reg = data[CNT_W-1:0];
            default:          ;
        endcase
        n_writes++;
    endtask

    task automatic send_band(input band_item_t b, input bit typed, input level_result_t want);
        level_result_t r;
        int            gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        item <= b;
        do @(posedge clk); while (full);
        if (predict_band(b, r))
            level_q.insert(level_q.size(), typed ? want : r);
        n_items++;
    endtask

    function automatic logic [MAG_W-1:0] pick_mag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return MAG_W'($urandom_range(0, 255));
            3:       return 16'hFFFF - MAG_W'($urandom_range(0, 255));
            default: return MAG_W'($urandom);
        endcase
    endfunction

    // mode 0: consecutive bands, 1: random bands, 2: one band repeated
    task automatic send_frame(input int len, input int mode, input bit broken);
        band_item_t    b;
        level_result_t none;
        int            start;
        none = '0;
        start = $urandom_range(0, MAX_BANDS - 1);
        for (int k = 0; k < len; k++)
        begin
            case (mode)
                0:       b.band_index = IDX_W'(start + k);
                1:       b.band_index = IDX_W'($urandom);
                default: b.band_index = IDX_W'(start);
            endcase
            b.band_magnitude = pick_mag();
            if (broken)
                b.frame_last = $urandom_range(0, 3) == 0;
            else
                b.frame_last = (k == len - 1);
            send_band(b, 1'b0, none);
        end
    endtask

    // receiver: segments of varying pop probability, plus one long hold-off
    initial
    begin
        int seg_left;
        int pct;
        pop <= 1'b0;
        seg_left = 0;
        pct = 100;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYC - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(20, 150);
                    case ($urandom_range(0, 3))
                        0:       pct = 100;
                        1:       pct = 75;
                        2:       pct = 35;
                        default: pct = 5;
                    endcase
                end
                seg_left--;
                pop <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            n_results++;
            if (level_q.size() == 0)
                flag_mismatch($sformatf("unexpected result %0d/%0d",
                              result.level_code, result.max_level_code));
            else
            begin
                mon_want = level_q.pop_front();
                if (result.level_code !== mon_want.level_code)
                    flag_mismatch($sformatf("level_code got %0d want %0d",
                                  result.level_code, mon_want.level_code));
                if (result.max_level_code !== mon_want.max_level_code)
                    flag_mismatch($sformatf("max_level_code got %0d want %0d",
                                  result.max_level_code, mon_want.max_level_code));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cyc <= 0;
        else if (idle_cyc >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     IDLE_LIMIT, level_q.size());
            $display("[peak_decay_spectrum_rms_meter] ERROR");
            $finish;
        end
        else
            idle_cyc <= idle_cyc + 1;
    end

    initial
    begin
        logic [MAG_W-1:0] decay_v;
        logic [CNT_W-1:0] count_v;
        band_item_t       b;
        level_result_t    none;
        int               sent;
        int               len;
        bit               paused;

        fail_cnt   = 0;
        n_items    = 0;
        n_results  = 0;
        n_writes   = 0;
        burst_left = 0;
        gap_max    = 3;
        hold_req   = 1'b0;
        none       = '0;
        for (int i = 0; i < MAX_BANDS; i++)
            smooth_mem[i] = '0;
        sum_acc   = '0;
        peak_lvl  = '0;
        decay_reg = DECAY_RESET;
        count_reg = COUNT_RESET;

        idle_cyc  <= 0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].data);
            else
                send_band(dir_tab[i].band, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       begin decay_v = '0;          count_v = 9'd1;   end
                1:       begin decay_v = '1;          count_v = 9'd256; end
                2:       begin decay_v = DECAY_RESET; count_v = 9'd8;   end
                3:       begin decay_v = MAG_W'($urandom);
                               count_v = CNT_W'($urandom_range(1, 256)); end
                4:       begin decay_v = MAG_W'($urandom); count_v = 9'd0; end
                5:       begin decay_v = '1;          count_v = 9'd511; end
                6:       begin decay_v = MAG_W'($urandom);
                               count_v = CNT_W'($urandom_range(1, 16)); end
                7:       begin decay_v = '0;          count_v = 9'd256; end
                8:       begin decay_v = MAG_W'($urandom);
                               count_v = CNT_W'($urandom_range(1, 511)); end
                default: begin decay_v = '1;          count_v = 9'd1;   end
            endcase
            write_reg(REG_DECAY_FACTOR, decay_v);
            write_reg(REG_BAND_COUNT, {7'($urandom), count_v});
            gap_max = (p % 3 == 1) ? 0 : $urandom_range(2, 20);

            if (p == HOLD_PHASE)
            begin
                // results back up while single-band frames keep coming
                hold_req = 1'b1;
                for (int k = 0; k < 16; k++)
                    send_frame(1, 1, 1'b0);
            end
            if (p == SAT_PHASE)
            begin
                // enough full-scale squares to hit the sum ceiling
                for (int k = 0; k < 264; k++)
                begin
                    b.band_index = IDX_W'(k);
                    b.band_magnitude = '1;
                    b.frame_last = (k == 263);
                    send_band(b, 1'b0, none);
                end
            end

            sent = 0;
            paused = 1'b0;
            while (sent < 6)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                    6, 7, 8:          len = $urandom_range(5, 16);
                    default:          len = $urandom_range(17, 48);
                endcase
                send_frame(len, $urandom_range(0, 2), $urandom_range(0, 9) == 0);
                sent += len;
                if (p == 4 && sent >= 3 && !paused)
                begin
                    drain_idle();
                    paused = 1'b1;
                end
            end
        end

        drain_idle();
        repeat (100) @(posedge clk);
        if (level_q.size() != 0)
            flag_mismatch($sformatf("%0d frame results never arrived", level_q.size()));

        $display("run: %0d band items, %0d frame results, %0d register writes",
                 n_items, n_results, n_writes);
        $display("run: decay and band count at extremes, sum ceiling, held results, %0d faults",
                 fail_cnt);
        if (fail_cnt == 0)
            $display("[peak_decay_spectrum_rms_meter] OK");
        else
            $display("[peak_decay_spectrum_rms_meter] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/pdsrm_pkg.sv
rtl/pdsrm_front.sv
rtl/pdsrm_job_fifo.sv
rtl/pdsrm_back.sv
rtl/peak_decay_spectrum_rms_meter.sv
verif/tb.sv
